// ===== rtl/core/rde_pkg.sv =====
`timescale 1ns / 1ps

package rde_pkg;

    localparam int BURST_LIMIT_DEF = 8;
    localparam logic [31:0] SEED_DEF = 32'd1;

    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;

    localparam logic [30:0] WAVE_MIN = 31'd3277;
    localparam logic [30:0] LIFE_MIN = 31'd655;

    localparam int QUEUE_DEPTH = 2;

    localparam int ADDR_W = 6;
    localparam logic [2:0] REG_ENABLED  = 3'd0;
    localparam logic [2:0] REG_RATE     = 3'd1;
    localparam logic [2:0] REG_HALF_X   = 3'd2;
    localparam logic [2:0] REG_HALF_Z   = 3'd3;
    localparam logic [2:0] REG_WAVE     = 3'd4;
    localparam logic [2:0] REG_SPEED    = 3'd5;
    localparam logic [2:0] REG_STRENGTH = 3'd6;
    localparam logic [2:0] REG_LIFE     = 3'd7;

    typedef struct packed {
        logic               enabled;
        logic signed [31:0] emit_rate;
        logic [31:0]        half_x;
        logic [31:0]        half_z;
        logic [3:0][63:0]   bounds;
    } t_cfg;

endpackage

// ===== rtl/core/rde_tick_if.sv =====
`timescale 1ns / 1ps

interface rde_tick_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] tick_seconds;

    modport source (output valid, output tick_seconds, input ready);
    modport sink (input valid, input tick_seconds, output ready);
endinterface

// ===== rtl/core/rde_ring_if.sv =====
`timescale 1ns / 1ps

interface rde_ring_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_z;
    logic [30:0]        ring_wavelength;
    logic signed [31:0] ring_speed;
    logic [30:0]        ring_strength;
    logic [30:0]        ring_lifetime;
    logic               last_ring;

    modport source (
        output valid, output centre_x, output centre_z, output ring_wavelength,
        output ring_speed, output ring_strength, output ring_lifetime,
        output last_ring, input ready
    );
    modport sink (
        input valid, input centre_x, input centre_z, input ring_wavelength,
        input ring_speed, input ring_strength, input ring_lifetime,
        input last_ring, output ready
    );
endinterface

// ===== rtl/core/rde_front.sv =====
`timescale 1ns / 1ps

module rde_front #(
    parameter int BURST_LIMIT = rde_pkg::BURST_LIMIT_DEF,
    localparam int CW = $clog2(BURST_LIMIT + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rde_pkg::t_cfg    i_cfg,
    rde_tick_if.sink         i_tick,
    output logic             o_push,
    output logic [CW-1:0]    o_count,
    input  logic             i_full
);

    localparam int SW = 47;
    localparam logic [SW-1:0] CAP = SW'(longint'(BURST_LIMIT) << 16);

    logic          r_pend;
    logic [61:0]   r_prod;
    logic [15:0]   r_debt;

    logic          w_active;
    logic          w_take;
    logic          w_done;
    logic          w_nonzero;
    logic [SW-1:0] w_sum;
    logic [SW-1:0] w_sum_sat;

    assign i_tick.ready = !r_pend;
    assign w_take = i_tick.valid && i_tick.ready;

    assign w_active = i_cfg.enabled
        && !i_cfg.emit_rate[31] && (|i_cfg.emit_rate[30:0])
        && !i_tick.tick_seconds[31] && (|i_tick.tick_seconds[30:0]);

    assign w_sum     = SW'(r_prod[61:16]) + SW'(r_debt);
    assign w_sum_sat = (w_sum > CAP) ? CAP : w_sum;
    assign o_count   = w_sum_sat[16 +: CW];
    assign w_nonzero = |o_count;
    assign w_done    = r_pend && (!w_nonzero || !i_full);
    assign o_push    = r_pend && w_nonzero && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_debt <= '0;
        end else begin
            if (w_take) begin
                r_pend <= w_active;
            end else if (w_done) begin
                r_pend <= 1'b0;
            end
            if (w_done) begin
                r_debt <= w_sum_sat[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_prod <= 62'(i_cfg.emit_rate[30:0]) * 62'(i_tick.tick_seconds[30:0]);
        end
    end

endmodule

// ===== rtl/core/rde_queue.sv =====
`timescale 1ns / 1ps

module rde_queue #(
    parameter int WIDTH = 4,
    parameter int DEPTH = rde_pkg::QUEUE_DEPTH,
    localparam int PW = $clog2(DEPTH),
    localparam int NW = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [NW-1:0]    r_cnt;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/core/rde_back.sv =====
`timescale 1ns / 1ps

module rde_back #(
    parameter int BURST_LIMIT = rde_pkg::BURST_LIMIT_DEF,
    parameter logic [31:0] SEED = rde_pkg::SEED_DEF,
    localparam int CW = $clog2(BURST_LIMIT + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rde_pkg::t_cfg i_cfg,
    input  logic          i_empty,
    input  logic [CW-1:0] i_count,
    output logic          o_pop,
    rde_ring_if.source    o_ring
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DRAW = 2'd1;
    localparam logic [1:0] S_SHOW = 2'd2;

    localparam logic [2:0] DRAW_CX = 3'd0;
    localparam logic [2:0] DRAW_CZ = 3'd1;
    localparam logic [2:0] DRAW_WL = 3'd2;
    localparam logic [2:0] DRAW_SP = 3'd3;
    localparam logic [2:0] DRAW_ST = 3'd4;
    localparam logic [2:0] DRAW_LT = 3'd5;

    localparam logic [1:0] PH_STEP = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_FOLD = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic [1:0]         r_state;
    logic [CW-1:0]      r_left;
    logic [2:0]         r_draw;
    logic [1:0]         r_phase;
    logic [31:0]        r_lcg;

    logic [47:0]        r_prod;
    logic               r_neg;
    logic signed [31:0] r_base;
    logic [31:0]        r_q0;
    logic [32:0]        r_y;

    logic signed [31:0] r_cx;
    logic signed [31:0] r_cz;
    logic [30:0]        r_wl;
    logic signed [31:0] r_sp;
    logic [30:0]        r_st;
    logic [30:0]        r_lt;

    logic [15:0]        w_u;
    logic [16:0]        w_twice;
    logic               w_centre;
    logic [1:0]         w_bidx;
    logic [63:0]        w_bnd;
    logic signed [31:0] w_a;
    logic signed [31:0] w_b;
    logic signed [31:0] w_lo;
    logic signed [31:0] w_hi;
    logic [32:0]        w_span;
    logic [31:0]        w_half;
    logic [31:0]        w_mag;
    logic [15:0]        w_fc;
    logic [31:0]        w_mspan;
    logic [15:0]        w_f;

    logic [16:0]        w_y1;
    logic [17:0]        w_z;
    logic [1:0]         w_corr;
    logic [32:0]        w_q;
    logic signed [33:0] w_qs;
    logic signed [33:0] w_base34;
    logic signed [33:0] w_v;

    // Operand selection for the multiply phase.
    assign w_u      = r_lcg[23:8];
    assign w_twice  = {w_u, 1'b0};
    assign w_centre = (r_draw == DRAW_CX) || (r_draw == DRAW_CZ);
    assign w_bidx   = 2'(r_draw - DRAW_WL);
    assign w_bnd    = i_cfg.bounds[w_bidx];
    assign w_a      = w_bnd[31:0];
    assign w_b      = w_bnd[63:32];
    assign w_lo     = (w_a < w_b) ? w_a : w_b;
    assign w_hi     = (w_a < w_b) ? w_b : w_a;
    assign w_span   = {w_hi[31], w_hi} - {w_lo[31], w_lo};
    assign w_half   = (r_draw == DRAW_CX) ? i_cfg.half_x : i_cfg.half_z;
    assign w_mag    = w_half[31] ? (~w_half + 32'd1) : w_half;
    assign w_fc     = w_u[15] ? 16'(w_twice - 17'd65535) : 16'(17'd65535 - w_twice);
    assign w_mspan  = w_centre ? w_mag : w_span[31:0];
    assign w_f      = w_centre ? w_fc : w_u;

    // The product divided by 65535, folded twice in sixteen-bit digits.
    assign w_y1     = r_y[32:16];
    assign w_z      = 18'(w_y1) + 18'(r_y[15:0]);
    assign w_corr   = (w_z >= 18'd131070) ? 2'd2 : ((w_z >= 18'd65535) ? 2'd1 : 2'd0);
    assign w_q      = 33'(r_q0) + 33'(w_y1) + 33'(w_corr);
    assign w_qs     = $signed({1'b0, w_q});
    assign w_base34 = {{2{r_base[31]}}, r_base};
    assign w_v      = w_base34 + (r_neg ? -w_qs : w_qs);

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    assign o_ring.valid           = (r_state == S_SHOW);
    assign o_ring.centre_x        = r_cx;
    assign o_ring.centre_z        = r_cz;
    assign o_ring.ring_wavelength = r_wl;
    assign o_ring.ring_speed      = r_sp;
    assign o_ring.ring_strength   = r_st;
    assign o_ring.ring_lifetime   = r_lt;
    assign o_ring.last_ring       = (r_left == CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
            r_draw  <= DRAW_CX;
            r_phase <= PH_STEP;
            r_lcg   <= SEED;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_left  <= i_count;
                        r_draw  <= DRAW_CX;
                        r_phase <= PH_STEP;
                        r_state <= S_DRAW;
                    end
                end
                S_DRAW: begin
                    r_phase <= r_phase + 2'd1;
                    if (r_phase == PH_STEP) begin
                        r_lcg <= r_lcg * rde_pkg::LCG_MUL + rde_pkg::LCG_ADD;
                    end
                    if (r_phase == PH_DONE) begin
                        if (r_draw == DRAW_LT) begin
                            r_draw  <= DRAW_CX;
                            r_state <= S_SHOW;
                        end else begin
                            r_draw <= r_draw + 3'd1;
                        end
                    end
                end
                S_SHOW: begin
                    if (o_ring.ready) begin
                        if (r_left == CW'(1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_left  <= r_left - CW'(1);
                            r_phase <= PH_STEP;
                            r_state <= S_DRAW;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DRAW) begin
            if (r_phase == PH_MUL) begin
                r_prod <= 48'(w_mspan) * 48'(w_f);
                r_neg  <= w_centre && !w_u[15];
                r_base <= w_centre ? 32'sd0 : w_lo;
            end
            if (r_phase == PH_FOLD) begin
                r_q0 <= r_prod[47:16];
                r_y  <= 33'(r_prod[47:16]) + 33'(r_prod[15:0]);
            end
            if (r_phase == PH_DONE) begin
                unique case (r_draw)
                    DRAW_CX: begin
                        r_cx <= (w_v > 34'sd2147483647) ? 32'h7FFF_FFFF : w_v[31:0];
                    end
                    DRAW_CZ: begin
                        r_cz <= (w_v > 34'sd2147483647) ? 32'h7FFF_FFFF : w_v[31:0];
                    end
                    DRAW_WL: begin
                        r_wl <= (w_v < $signed({3'b000, rde_pkg::WAVE_MIN}))
                            ? rde_pkg::WAVE_MIN : w_v[30:0];
                    end
                    DRAW_SP: begin
                        r_sp <= w_v[31:0];
                    end
                    DRAW_ST: begin
                        r_st <= (w_v < 34'sd0) ? 31'd0 : w_v[30:0];
                    end
                    DRAW_LT: begin
                        r_lt <= (w_v < $signed({3'b000, rde_pkg::LIFE_MIN}))
                            ? rde_pkg::LIFE_MIN : w_v[30:0];
                    end
                    default: begin
                        r_sp <= r_sp;
                    end
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/rate_debt_random_emitter.sv =====
`timescale 1ns / 1ps

// Rate-debt ring emitter. Each beat on i_tick is one time tick in Q16.16
// seconds. When the block is enabled and both the rate and the tick are
// positive, their product is added to a fractional ring debt that is capped
// at BURST_LIMIT rings, and every whole ring of debt leaves on o_ring as one
// beat; last_ring marks the final beat caused by a tick.
// An active tick is taken and its product registered; no new tick is taken
// until its ring count, if nonzero, is pushed into the ring-count queue.
// Each ring needs six draws of the shared generator, each a step, multiply,
// fold and done phase on the one multiply-and-divide path, and the next
// ring is drawn only after the current one is taken on o_ring.
// A stall on o_ring holds the current ring; ticks keep being accepted until
// the two-entry ring-count queue is full.
// Registers must be written over the APB port only while no rings are
// pending; the block does not enforce this. Reset clears all registers,
// the debt and the queue, and loads the generator with SEED.
module rate_debt_random_emitter #(
    parameter int BURST_LIMIT = rde_pkg::BURST_LIMIT_DEF,
    parameter logic [31:0] SEED = rde_pkg::SEED_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    rde_tick_if.sink                   i_tick,
    rde_ring_if.source                 o_ring,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rde_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic                       pready
);

    localparam int CW = $clog2(BURST_LIMIT + 1);

    rde_pkg::t_cfg r_cfg;
    logic [2:0]    w_idx;
    logic          w_wr;
    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    logic [CW-1:0] w_push_count;
    logic [CW-1:0] w_pop_count;

    assign pready = 1'b1;
    assign w_idx  = paddr[5:3];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                rde_pkg::REG_ENABLED:  r_cfg.enabled   <= pwdata[0];
                rde_pkg::REG_RATE:     r_cfg.emit_rate <= pwdata[31:0];
                rde_pkg::REG_HALF_X:   r_cfg.half_x    <= pwdata[31:0];
                rde_pkg::REG_HALF_Z:   r_cfg.half_z    <= pwdata[31:0];
                rde_pkg::REG_WAVE:     r_cfg.bounds[0] <= pwdata;
                rde_pkg::REG_SPEED:    r_cfg.bounds[1] <= pwdata;
                rde_pkg::REG_STRENGTH: r_cfg.bounds[2] <= pwdata;
                rde_pkg::REG_LIFE:     r_cfg.bounds[3] <= pwdata;
                default:               r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            rde_pkg::REG_ENABLED:  prdata = {63'd0, r_cfg.enabled};
            rde_pkg::REG_RATE:     prdata = {32'd0, r_cfg.emit_rate};
            rde_pkg::REG_HALF_X:   prdata = {32'd0, r_cfg.half_x};
            rde_pkg::REG_HALF_Z:   prdata = {32'd0, r_cfg.half_z};
            rde_pkg::REG_WAVE:     prdata = r_cfg.bounds[0];
            rde_pkg::REG_SPEED:    prdata = r_cfg.bounds[1];
            rde_pkg::REG_STRENGTH: prdata = r_cfg.bounds[2];
            rde_pkg::REG_LIFE:     prdata = r_cfg.bounds[3];
            default:               prdata = '0;
        endcase
    end

    rde_front #(
        .BURST_LIMIT(BURST_LIMIT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_tick  (i_tick),
        .o_push  (w_push),
        .o_count (w_push_count),
        .i_full  (w_full)
    );

    rde_queue #(
        .WIDTH(CW),
        .DEPTH(rde_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_count),
        .i_pop   (w_pop),
        .o_data  (w_pop_count),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    rde_back #(
        .BURST_LIMIT(BURST_LIMIT),
        .SEED(SEED)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (w_empty),
        .i_count (w_pop_count),
        .o_pop   (w_pop),
        .o_ring  (o_ring)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("ring count pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("ring count popped from an empty queue");

    a_wave_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ring.valid |-> (o_ring.ring_wavelength >= rde_pkg::WAVE_MIN)
            && (o_ring.ring_lifetime >= rde_pkg::LIFE_MIN))
        else $error("ring shown with wavelength or lifetime below its floor");

    a_ring_nonzero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_push_count != '0))
        else $error("empty ring count queued");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import rde_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_ITEMS = 300;
    localparam int IDLE_PCT = 26;
    localparam int HOLD_CYCLES = 1000;
    localparam logic [63:0] DEBT_CAP = 64'(BURST_LIMIT_DEF) << 16;

    typedef struct packed {
        logic signed [31:0] centre_x;
        logic signed [31:0] centre_z;
        logic [30:0]        wavelength;
        logic signed [31:0] speed;
        logic [30:0]        strength;
        logic [30:0]        lifetime;
        logic               last_ring;
    } t_ring;

    typedef enum {ROW_WRITE, ROW_TICK} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  reg_idx;
        logic [63:0] value;
        int          typed_rings;
    } t_plan_row;

    localparam t_ring FLAT_RING = '{
        centre_x: '0, centre_z: '0, wavelength: WAVE_MIN, speed: 32'sh8000_0000,
        strength: '0, lifetime: LIFE_MIN, last_ring: 1'b0
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [63:0]       pwdata;
    logic [63:0]       prdata;
    logic              pready;

    rde_tick_if tick_bus ();
    rde_ring_if ring_bus ();

    rate_debt_random_emitter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_bus),
        .o_ring  (ring_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_cfg        model_cfg = '0;
    logic [19:0] debt = '0;
    logic [31:0] gen_state = SEED_DEF;
    t_ring       pending_rings[$];
    t_plan_row   plan[$];
    int          mismatch_count = 0;
    int          sent_ticks = 0;
    int          idle_pct = IDLE_PCT;
    int          ring_hold = 0;
    int          cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint next_unit();
        gen_state = gen_state * LCG_MUL + LCG_ADD;
        return longint'(gen_state[23:8]);
    endfunction

    function automatic longint range_sample(logic [63:0] bounds);
        longint a, b, lo, hi;
        a = $signed(bounds[31:0]);
        b = $signed(bounds[63:32]);
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return lo + (hi - lo) * next_unit() / 65535;
    endfunction

    function automatic logic signed [31:0] centre_sample(logic [31:0] half);
        longint mag, r;
        mag = $signed(half);
        if (mag < 0) mag = -mag;
        r = mag * (2 * next_unit() - 65535) / 65535;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        return r[31:0];
    endfunction

    function automatic bit predict_tick(logic signed [31:0] tick, bit keep);
        logic [63:0] sum;
        int unsigned count;
        int unsigned k;
        t_ring ring;
        longint wl, sp, st, lt;
        if (!model_cfg.enabled || model_cfg.emit_rate <= 0 || tick <= 0) return 1'b0;
        sum = 64'(debt) + (({32'd0, model_cfg.emit_rate} * {32'd0, tick}) >> 16);
        if (sum > DEBT_CAP) sum = DEBT_CAP;
        count = 32'(sum >> 16);
        debt = 20'(sum - (64'(count) << 16));
        for (k = 0; k < count; k++) begin
            ring.centre_x = centre_sample(model_cfg.half_x);
            ring.centre_z = centre_sample(model_cfg.half_z);
            wl = range_sample(model_cfg.bounds[0]);
            sp = range_sample(model_cfg.bounds[1]);
            st = range_sample(model_cfg.bounds[2]);
            lt = range_sample(model_cfg.bounds[3]);
            if (wl < longint'(WAVE_MIN)) wl = WAVE_MIN;
            if (st < 0) st = 0;
            if (lt < longint'(LIFE_MIN)) lt = LIFE_MIN;
            ring.speed = sp[31:0];
            ring.wavelength = wl[30:0];
            ring.strength = st[30:0];
            ring.lifetime = lt[30:0];
            ring.last_ring = (k == count - 1);
            if (keep) pending_rings.insert(pending_rings.size(), ring);
        end
        return 1'b1;
    endfunction

    function automatic void plan_write(logic [2:0] idx, logic [63:0] value);
        t_plan_row row;
        row.kind = ROW_WRITE;
        row.reg_idx = idx;
        row.value = value;
        row.typed_rings = -1;
        plan.insert(plan.size(), row);
    endfunction

    function automatic void plan_tick(logic [31:0] tick, int typed_rings);
        t_plan_row row;
        row.kind = ROW_TICK;
        row.reg_idx = REG_ENABLED;
        row.value = {32'd0, tick};
        row.typed_rings = typed_rings;
        plan.insert(plan.size(), row);
    endfunction

    function automatic logic [31:0] random_tick();
        case ($urandom_range(0, 19))
            0: return $urandom();
            1: return 32'h0;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000 | $urandom();
            default: return $urandom_range(1, 32'h3_0000);
        endcase
    endfunction

    task automatic note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) note_failure($sformatf("%s expected %h, got %h", name, want, got));
    endtask

    task automatic reg_write(logic [2:0] idx, logic [63:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_ENABLED: model_cfg.enabled = value[0];
            REG_RATE:    model_cfg.emit_rate = value[31:0];
            REG_HALF_X:  model_cfg.half_x = value[31:0];
            REG_HALF_Z:  model_cfg.half_z = value[31:0];
            default:     model_cfg.bounds[2'(idx - REG_WAVE)] = value;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_tick(logic [31:0] tick, int typed_rings);
        t_ring ring;
        int k;
        while ($urandom_range(0, 99) < idle_pct) begin
            tick_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        tick_bus.valid <= 1'b1;
        tick_bus.tick_seconds <= tick;
        @(posedge i_clk);
        while (!tick_bus.ready) @(posedge i_clk);
        void'(predict_tick(tick, typed_rings < 0));
        sent_ticks++;
        for (k = 0; k < typed_rings; k++) begin
            ring = FLAT_RING;
            ring.last_ring = (k == typed_rings - 1);
            pending_rings.insert(pending_rings.size(), ring);
        end
        @(negedge i_clk);
    endtask

    task automatic quiesce(int extra);
        tick_bus.valid <= 1'b0;
        while (pending_rings.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_setup(bit busy);
        logic [63:0] v;
        int idx;
        v = {$urandom(), $urandom()};
        v[0] = busy || ($urandom_range(0, 9) != 0);
        reg_write(REG_ENABLED, v);
        if (busy) begin
            v = $urandom_range(32'h1_0000, 32'h4_0000);
        end else begin
            case ($urandom_range(0, 9))
                0: v = {$urandom(), $urandom()};
                1: v = 64'h7FFF_FFFF;
                2: v = $urandom_range(0, 1) ? 64'h0 : {32'h0, 32'h8000_0000 | $urandom()};
                default: v = $urandom_range(32'h2000, 32'h4_0000);
            endcase
        end
        reg_write(REG_RATE, v);
        for (idx = REG_HALF_X; idx <= REG_HALF_Z; idx++) begin
            case ($urandom_range(0, 3))
                0: v = $urandom();
                1: v = 32'h8000_0000;
                default: begin
                    v = $urandom_range(0, 32'h14_0000);
                    if ($urandom_range(0, 1)) v = {32'h0, 32'h0 - v[31:0]};
                end
            endcase
            reg_write(3'(idx), v);
        end
        for (idx = REG_WAVE; idx <= REG_LIFE; idx++) begin
            case ($urandom_range(0, 3))
                0: v = {$urandom(), $urandom()};
                1: begin
                    v[31:0] = $urandom();
                    v[63:32] = v[31:0];
                end
                default: begin
                    v[31:0] = $urandom_range(0, 32'h14_0000) - 32'h000A_0000;
                    v[63:32] = $urandom_range(0, 32'h14_0000) - 32'h000A_0000;
                end
            endcase
            reg_write(3'(idx), v);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Every ring beat is checked against the oldest ring still expected.
    always @(posedge i_clk) begin
        t_ring want;
        if (i_rst_n && ring_bus.valid && ring_bus.ready) begin
            if (pending_rings.size() == 0) begin
                note_failure("ring beat arrived with no ring expected");
            end else begin
                want = pending_rings.pop_front();
                check_field("centre_x", want.centre_x, ring_bus.centre_x);
                check_field("centre_z", want.centre_z, ring_bus.centre_z);
                check_field("ring_wavelength", want.wavelength, ring_bus.ring_wavelength);
                check_field("ring_speed", want.speed, ring_bus.ring_speed);
                check_field("ring_strength", want.strength, ring_bus.ring_strength);
                check_field("ring_lifetime", want.lifetime, ring_bus.ring_lifetime);
                check_field("last_ring", want.last_ring, ring_bus.last_ring);
            end
        end
    end

    initial begin
        ring_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (ring_hold > 0) begin
                ring_hold--;
                ring_bus.ready <= 1'b0;
            end else begin
                ring_bus.ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    initial begin
        int burst;
        int n;
        int random_phase;
        bit after_tick;

        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tick_bus.valid = 1'b0;
        tick_bus.tick_seconds = '0;

        plan_tick(32'h0001_0000, 0);
        plan_write(REG_ENABLED, 64'd1);
        plan_tick(32'h0001_0000, 0);
        plan_write(REG_RATE, 64'hFFFF_0000);
        plan_tick(32'h0001_0000, 0);
        plan_write(REG_RATE, 64'h0001_0000);
        plan_write(REG_WAVE, 64'h0);
        plan_write(REG_SPEED, 64'h8000_0000_8000_0000);
        plan_write(REG_STRENGTH, 64'hFFFF_0000_FFFF_0000);
        plan_write(REG_LIFE, 64'h0);
        plan_tick(32'h0000_0000, 0);
        plan_tick(32'h8000_0000, 0);
        plan_tick(32'h0001_0000, 1);
        plan_tick(32'h7FFF_FFFF, 8);
        plan_write(REG_RATE, 64'h7FFF_FFFF);
        plan_tick(32'h0000_0001, -1);
        plan_tick(32'h0000_0001, -1);
        plan_tick(32'h0000_0002, -1);
        plan_tick(32'h7FFF_FFFF, 8);
        plan_write(REG_HALF_X, 64'h8000_0000);
        plan_write(REG_HALF_Z, 64'h7FFF_FFFF);
        plan_write(REG_WAVE, 64'h7FFF_FFFF_8000_0000);
        plan_write(REG_SPEED, 64'h0001_0000_FFFF_0000);
        plan_write(REG_STRENGTH, 64'h0000_0000_7FFF_FFFF);
        plan_write(REG_LIFE, 64'h8000_0000_7FFF_FFFF);
        plan_tick(32'h7FFF_FFFF, -1);
        plan_tick(32'h0000_4000, -1);
        plan_write(REG_RATE, 64'h0001_8000);
        plan_tick(32'h0001_0000, -1);
        plan_tick(32'h0001_0000, -1);
        plan_tick(32'hFFFF_FFFF, 0);
        plan_write(REG_ENABLED, 64'd0);
        plan_tick(32'h7FFF_FFFF, 0);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        after_tick = 1'b0;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                if (after_tick) quiesce(64);
                reg_write(plan[i].reg_idx, plan[i].value);
                after_tick = 1'b0;
            end else begin
                send_tick(plan[i].value[31:0], plan[i].typed_rings);
                after_tick = 1'b1;
            end
        end

        sent_ticks = 0;
        random_phase = 0;
        while (sent_ticks < RANDOM_ITEMS) begin
            quiesce(64);
            idle_pct = (random_phase == 1) ? 0 : IDLE_PCT;
            random_setup(random_phase == 1 || random_phase == 3);
            if (random_phase == 3) ring_hold = HOLD_CYCLES;
            burst = $urandom_range(15, 35);
            for (n = 0; n < burst; n++) begin
                if (random_phase == 5 && n == burst / 2) quiesce(0);
                send_tick(random_tick(), -1);
            end
            random_phase++;
        end

        quiesce(300);
        if (mismatch_count == 0 && pending_rings.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
